### src/hnt_pkg.sv
// ----------------------------------------------------------------------------
// hnt_pkg
// Shared widths, constants and handshake structs of the happy number test.
// ----------------------------------------------------------------------------
package hnt_pkg;

    localparam int NUM_W   = 31;   // width of the tested number
    localparam int RADIX_W = 8;    // width of the radix register
    // A digit square sum never exceeds 4 * 254 * 254 for a 31-bit value.
    localparam int SUM_W   = 18;
    localparam int WIN_W   = 20;   // window length and step counter width
    localparam int CNT_W   = 5;    // divider bit counter
    localparam int SMALL_SHIFT = NUM_W - SUM_W;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;

    localparam logic [WIN_W-1:0] FIRST_WINDOW = 20'd10;
    localparam logic [WIN_W-1:0] WINDOW_STEP  = 20'd10;

    // Configuration register indexes.
    localparam logic CFG_RADIX    = 1'b0;
    localparam logic CFG_ECSTATIC = 1'b1;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   value;
        logic [RADIX_W-1:0] base;
    } dsu_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
    } dsu_rsp_t;

endpackage

### src/hnt_digit_unit.sv
// ----------------------------------------------------------------------------
// hnt_digit_unit
// Iterative digit square sum: a restoring divider peels off one digit at a
// time, the digit is squared and added to a running sum.
// ----------------------------------------------------------------------------
module hnt_digit_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  hnt_pkg::dsu_req_t req,
    output hnt_pkg::dsu_rsp_t rsp
);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_DIV  = 2'd1;
    localparam logic [1:0] U_SQR  = 2'd2;
    localparam logic [1:0] U_ACC  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic                         done_reg, done_next;
    logic [hnt_pkg::NUM_W-1:0]    quo_reg, quo_next;
    logic [hnt_pkg::RADIX_W-1:0]  rem_reg, rem_next;
    logic [hnt_pkg::RADIX_W-1:0]  base_reg, base_next;
    logic [hnt_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [2*hnt_pkg::RADIX_W-1:0] sq_reg, sq_next;
    logic [hnt_pkg::SUM_W-1:0]    acc_reg, acc_next;

    logic [hnt_pkg::NUM_W-1:0]    load_src;
    logic                         load_small;
    logic [hnt_pkg::NUM_W-1:0]    load_quo;
    logic [hnt_pkg::CNT_W-1:0]    load_cnt;
    logic [hnt_pkg::RADIX_W:0]    partial;
    logic [hnt_pkg::RADIX_W:0]    diff;
    logic                         ge;

    // A value that fits the sum width is pre-shifted so that the divider
    // skips its known zero upper bits.
    assign load_src   = (state_reg == U_IDLE) ? req.value : quo_reg;
    assign load_small = (load_src[hnt_pkg::NUM_W-1:hnt_pkg::SUM_W] == '0);
    assign load_quo   = load_small
                      ? {load_src[hnt_pkg::SUM_W-1:0], {hnt_pkg::SMALL_SHIFT{1'b0}}}
                      : load_src;
    assign load_cnt   = load_small ? hnt_pkg::CNT_W'(hnt_pkg::SUM_W - 1)
                                   : hnt_pkg::CNT_W'(hnt_pkg::NUM_W - 1);

    assign partial = {rem_reg, quo_reg[hnt_pkg::NUM_W-1]};
    assign ge      = (partial >= {1'b0, base_reg});
    assign diff    = partial - {1'b0, base_reg};

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    base_next = req.base;
                    acc_next  = '0;
                    if (req.value == '0) begin
                        done_next = 1'b1;
                    end else begin
                        quo_next   = load_quo;
                        rem_next   = '0;
                        cnt_next   = load_cnt;
                        state_next = U_DIV;
                    end
                end
            end
            U_DIV: begin
                quo_next = {quo_reg[hnt_pkg::NUM_W-2:0], ge};
                rem_next = ge ? diff[hnt_pkg::RADIX_W-1:0]
                              : partial[hnt_pkg::RADIX_W-1:0];
                if (cnt_reg == '0) begin
                    state_next = U_SQR;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            U_SQR: begin
                sq_next    = rem_reg * rem_reg;
                state_next = U_ACC;
            end
            U_ACC: begin
                acc_next = acc_reg + hnt_pkg::SUM_W'(sq_reg);
                if (quo_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end else begin
                    quo_next   = load_quo;
                    rem_next   = '0;
                    cnt_next   = load_cnt;
                    state_next = U_DIV;
                end
            end
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        cnt_reg  <= cnt_next;
        sq_reg   <= sq_next;
        acc_reg  <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sum  = acc_reg;

endmodule

### src/happy_number_test.sv
// A number is tested by iterating the digit square sum in the configured radix
// until a repeat of a checkpoint value is seen; the answer is 1 when that value
// is 1. In ecstatic mode every radix from 2 to the configured one is tested in
// turn, stopping at the first failure. One item is in work at a time and
// s_tready is low meanwhile. All arithmetic runs through one bit-serial
// divider with a squarer and adder behind it: each digit takes a division over
// all 31 bits of the value while it is 2**18 or more and over its low 18 bits
// below that, then a square and an add, and each iterate adds sequencing
// through the sum, wait and evaluate states. A finished result waits in the
// output register while the next item is already taken.
// ----------------------------------------------------------------------------
// happy_number_test
// Happy (and ecstatic) number tester with checkpoint-window cycle detection.
// ----------------------------------------------------------------------------
module happy_number_test (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_wr_en,
    input  logic                        cfg_addr,
    input  logic [hnt_pkg::RADIX_W-1:0] cfg_wr_data,
    // Input items.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [30:0] number
    // Result items.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [0] happy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BASE = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [hnt_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic                        ecs_cfg_reg, ecs_cfg_next;

    logic [2:0]                  state_reg, state_next;
    logic [hnt_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [hnt_pkg::NUM_W-1:0]   v_reg, v_next;
    logic [hnt_pkg::NUM_W-1:0]   mark_reg, mark_next;
    logic [hnt_pkg::WIN_W-1:0]   window_reg, window_next;
    logic [hnt_pkg::WIN_W-1:0]   j_reg, j_next;
    logic [hnt_pkg::RADIX_W-1:0] base_reg, base_next;
    logic [hnt_pkg::RADIX_W-1:0] top_reg, top_next;
    logic                        ecs_reg, ecs_next;
    logic                        result_reg, result_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        m_happy_reg, m_happy_next;

    logic [hnt_pkg::RADIX_W-1:0] top_eff;
    logic                        in_accept;
    logic                        is_one;
    logic [hnt_pkg::WIN_W-1:0]   window_grown;

    hnt_pkg::dsu_req_t dsu_req;
    hnt_pkg::dsu_rsp_t dsu_rsp;

    hnt_digit_unit u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dsu_req),
        .rsp     (dsu_rsp)
    );

    assign top_eff      = (radix_reg < hnt_pkg::RADIX_MIN) ? hnt_pkg::RADIX_MIN : radix_reg;
    assign s_tready     = (state_reg == S_IDLE);
    assign in_accept    = s_tvalid && s_tready;
    assign is_one       = (v_reg == hnt_pkg::NUM_W'(1));
    assign window_grown = window_reg + hnt_pkg::WINDOW_STEP;

    assign dsu_req.start = (state_reg == S_SUM);
    assign dsu_req.value = v_reg;
    assign dsu_req.base  = base_reg;

    always_comb begin
        radix_next   = radix_reg;
        ecs_cfg_next = ecs_cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                hnt_pkg::CFG_RADIX:    radix_next   = cfg_wr_data;
                hnt_pkg::CFG_ECSTATIC: ecs_cfg_next = cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        num_next     = num_reg;
        v_next       = v_reg;
        mark_next    = mark_reg;
        window_next  = window_reg;
        j_next       = j_reg;
        base_next    = base_reg;
        top_next     = top_reg;
        ecs_next     = ecs_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_happy_next = m_happy_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    num_next   = s_tdata[hnt_pkg::NUM_W-1:0];
                    top_next   = top_eff;
                    ecs_next   = ecs_cfg_reg;
                    base_next  = ecs_cfg_reg ? hnt_pkg::RADIX_MIN : top_eff;
                    state_next = S_BASE;
                end
            end
            S_BASE: begin
                v_next      = num_reg;
                mark_next   = num_reg;
                window_next = hnt_pkg::FIRST_WINDOW;
                j_next      = hnt_pkg::FIRST_WINDOW;
                state_next  = S_SUM;
            end
            S_SUM: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (dsu_rsp.done) begin
                    v_next     = hnt_pkg::NUM_W'(dsu_rsp.sum);
                    j_next     = j_reg - 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (v_reg == mark_reg) begin
                    // The checkpoint repeated: this base is settled.
                    if (ecs_reg && is_one && (base_reg != top_reg)) begin
                        base_next  = base_reg + 1'b1;
                        state_next = S_BASE;
                    end else begin
                        result_next = is_one;
                        state_next  = S_DONE;
                    end
                end else if (j_reg == '0) begin
                    // Window used up without a match: move the checkpoint on.
                    window_next = window_grown;
                    j_next      = window_grown;
                    mark_next   = v_reg;
                    state_next  = S_SUM;
                end else begin
                    state_next = S_SUM;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_happy_next = result_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg   <= hnt_pkg::RADIX_RESET;
            ecs_cfg_reg <= 1'b0;
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            radix_reg   <= radix_next;
            ecs_cfg_reg <= ecs_cfg_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        num_reg     <= num_next;
        v_reg       <= v_next;
        mark_reg    <= mark_next;
        window_reg  <= window_next;
        j_reg       <= j_next;
        base_reg    <= base_next;
        top_reg     <= top_next;
        ecs_reg     <= ecs_next;
        result_reg  <= result_next;
        m_happy_reg <= m_happy_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_happy_reg};

    // The digit unit answers only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        dsu_rsp.done |-> state_reg == S_WAIT)
        else $error("digit unit finished outside of the wait state");

    // A sum request is always followed by the wait state.
    a_start_then_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        dsu_req.start |=> state_reg == S_WAIT)
        else $error("sum request not followed by wait");

    // The base under test stays within 2 and the top radix during work.
    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (base_reg >= hnt_pkg::RADIX_MIN) && (base_reg <= top_reg))
        else $error("base out of range");

    // The step counter never exceeds the current window.
    a_step_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL) |-> (j_reg < window_reg))
        else $error("step counter beyond window");

endmodule

### tb/sv/tb_happy_number_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_happy_number_test
// Self-checking bench for the happy number tester. Numbers are streamed in
// under several radix and ecstatic settings. Each verdict is predicted by
// iterating the digit square sum with the same checkpoint-window loop
// detection, and every returned item is compared against the oldest
// prediction. Both stream sides stall at random in changing proportions.
// ----------------------------------------------------------------------------
module tb_happy_number_test;

    localparam int WATCHDOG_LIMIT = 50_000_000;
    localparam int DRAIN_CYCLES   = 50;

    typedef struct {
        logic [hnt_pkg::NUM_W-1:0] number;
        logic                      happy;
    } verdict_t;

    logic                        aclk;
    logic                        aresetn     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic                        cfg_addr    = hnt_pkg::CFG_RADIX;
    logic [hnt_pkg::RADIX_W-1:0] cfg_wr_data = '0;
    logic                        s_tvalid    = 1'b0;
    logic                        s_tready;
    logic [31:0]                 s_tdata     = '0;   // [30:0] number
    logic                        m_tvalid;
    logic                        m_tready    = 1'b0;
    logic [7:0]                  m_tdata;            // [0] happy

    // Register copies used by the predictor.
    logic [hnt_pkg::RADIX_W-1:0] model_radix    = hnt_pkg::RADIX_RESET;
    logic                        model_ecstatic = 1'b0;

    verdict_t    pending_verdicts[$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned ready_gap_pct  = 0;

    happy_number_test uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned digit_square_total(int unsigned value,
                                                       int unsigned base);
        int unsigned total;
        int unsigned digit;
        total = 0;
        while (value != 0) begin
            digit = value % base;
            value = value / base;
            total += digit * digit;
        end
        return total;
    endfunction

    // Iterate from a checkpoint for a growing window until the checkpoint
    // recurs; the recurring value decides the answer.
    function automatic bit reaches_one(int unsigned start, int unsigned base);
        int unsigned value;
        int unsigned mark;
        int unsigned window;
        int unsigned step;
        bit          repeated;
        value    = start;
        window   = hnt_pkg::FIRST_WINDOW;
        repeated = 1'b0;
        while (!repeated) begin
            mark = value;
            step = 0;
            while (step < window && !repeated) begin
                value    = digit_square_total(value, base);
                repeated = (value == mark);
                step++;
            end
            window += hnt_pkg::WINDOW_STEP;
        end
        return value == 1;
    endfunction

    function automatic logic happy_verdict(logic [hnt_pkg::NUM_W-1:0] number);
        int unsigned top;
        int unsigned base;
        bit          all_happy;
        top = (model_radix < hnt_pkg::RADIX_MIN) ? hnt_pkg::RADIX_MIN : model_radix;
        if (!model_ecstatic) begin
            return reaches_one(number, top);
        end
        all_happy = 1'b1;
        base      = hnt_pkg::RADIX_MIN;
        while (base <= top && all_happy) begin
            all_happy = reaches_one(number, base);
            base++;
        end
        return all_happy;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Called at a falling edge. The valid of an item accepted at the previous
    // rising edge is still high here and is either reused or lowered once.
    task automatic send_number(input logic [hnt_pkg::NUM_W-1:0] number);
        verdict_t entry;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, number};
        do @(posedge aclk); while (!s_tready);
        entry.number = number;
        entry.happy  = happy_verdict(number);
        pending_verdicts.push_back(entry);
        @(negedge aclk);
    endtask

    // Every item yields a result, so the block is idle once all have returned.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic addr,
                                  input logic [hnt_pkg::RADIX_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == hnt_pkg::CFG_RADIX) begin
            model_radix = value;
        end else begin
            model_ecstatic = value[0];
        end
    endtask

    task automatic set_mode(input logic ecstatic);
        logic [hnt_pkg::RADIX_W-2:0] junk;
        junk = (hnt_pkg::RADIX_W-1)'($urandom_range(127));
        write_register(hnt_pkg::CFG_ECSTATIC, {junk, ecstatic});
    endtask

    function automatic logic [hnt_pkg::NUM_W-1:0] pick_number();
        case ($urandom_range(3))
            0:       return hnt_pkg::NUM_W'($urandom_range(999));
            1:       return hnt_pkg::NUM_W'($urandom_range(65535));
            default: return hnt_pkg::NUM_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_settings();
        send_number(0);
        send_number(1);
        send_number(7);
        send_number(4);
        send_number(19);
        send_number(31'h7FFF_FFFF);
        send_number(31'h2AAA_AAAA);
        send_number(31'h5555_5555);
    endtask

    task automatic test_radix_limits();
        // A radix of zero or one behaves as two.
        write_register(hnt_pkg::CFG_RADIX, 8'd0);
        send_number(5);
        send_number(31'h7FFF_FFFF);
        write_register(hnt_pkg::CFG_RADIX, 8'd1);
        send_number(3);
        write_register(hnt_pkg::CFG_RADIX, 8'd255);
        send_number(254);
        send_number(255);
        send_number(65025);
        send_number(31'h7FFF_FFFF);
        write_register(hnt_pkg::CFG_RADIX, 8'd2);
        send_number(6);
    endtask

    task automatic test_ecstatic_limits();
        set_mode(1'b1);
        write_register(hnt_pkg::CFG_RADIX, 8'd0);
        send_number(0);
        send_number(9);
        write_register(hnt_pkg::CFG_RADIX, 8'd1);
        send_number(12);
        // One is happy in every base; two fails already in base three.
        write_register(hnt_pkg::CFG_RADIX, 8'd255);
        send_number(1);
        send_number(2);
        write_register(hnt_pkg::CFG_RADIX, 8'd4);
        send_number(3);
        send_number(7);
    endtask

    task automatic test_random_single_radix(input int unsigned count);
        set_mode(1'b0);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 10 == 0) begin
                write_register(hnt_pkg::CFG_RADIX,
                               hnt_pkg::RADIX_W'($urandom_range(255)));
            end
            send_number(pick_number());
        end
    endtask

    task automatic test_random_ecstatic(input int unsigned count);
        set_mode(1'b1);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 10 == 0) begin
                write_register(hnt_pkg::CFG_RADIX,
                               hnt_pkg::RADIX_W'($urandom_range(16)));
            end
            send_number(pick_number());
        end
    endtask

    task automatic test_random_mixed(input int unsigned count);
        logic ecstatic;
        ecstatic = 1'b0;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 10 == 0) begin
                ecstatic = 1'($urandom_range(1));
                set_mode(ecstatic);
                // Keep ecstatic runs short: every base up to the radix is tried.
                write_register(hnt_pkg::CFG_RADIX, hnt_pkg::RADIX_W'(
                    ecstatic ? $urandom_range(16) : $urandom_range(255)));
            end
            send_number(pick_number());
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_gap_pct  = 23;
        ready_gap_pct = 69;
        test_reset_settings();
        test_radix_limits();
        test_ecstatic_limits();
        test_random_single_radix(30);

        send_gap_pct  = 69;
        ready_gap_pct = 23;
        test_random_ecstatic(25);

        send_gap_pct  = 0;
        ready_gap_pct = 0;
        test_random_mixed(25);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= ready_gap_pct);
    end

    always @(posedge aclk) begin
        verdict_t oldest;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result item with no outstanding number: happy = %0b", m_tdata[0]);
                mismatch_count++;
            end else begin
                oldest = pending_verdicts.pop_front();
                if (m_tdata[0] !== oldest.happy) begin
                    $error("happy mismatch for number %0d: expected %0b, actual %0b",
                           oldest.number, oldest.happy, m_tdata[0]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
